[hw/rtl/assert_macros.svh]
// assert_macros.svh: concurrent assertion macros for the range maximum tree.
// Included by files that carry assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/rmat_pkg.sv]
// rmat_pkg: constants, node type and opcodes of the range maximum tree.
// No dependencies; used by the interfaces, rmat_pick and range_max_argmax_tree.
`timescale 1ns / 1ps

package rmat_pkg;

    // Slot count and field widths
    localparam int LEAVES     = 1024;
    localparam int POS_BITS   = 10;
    localparam int END_BITS   = 11;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = 10;

    // Tree geometry: leaves rounded up to a power of two, nodes 1 .. 2*TREE_W-1
    localparam int TREE_W    = 1 << $clog2(LEAVES);
    localparam int ADDR_BITS = $clog2(TREE_W) + 1;
    localparam int IDX_BITS  = ADDR_BITS + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                         full;
        logic signed [VALUE_BITS-1:0] val;
        logic        [SLOT_BITS-1:0]  slot;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

endpackage

[hw/rtl/rmat_in_if.sv]
// rmat_in_if: input channel of the range maximum tree (valid/ready + item).
// Depends on rmat_pkg for field widths.
`timescale 1ns / 1ps

interface rmat_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  opcode;
    logic        [rmat_pkg::POS_BITS-1:0]   position;
    logic        [rmat_pkg::END_BITS-1:0]   range_end;
    logic signed [rmat_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, opcode, position, range_end, value, input ready);
    modport sink   (input valid, opcode, position, range_end, value, output ready);
endinterface

[hw/rtl/rmat_out_if.sv]
// rmat_out_if: result channel of the range maximum tree (valid/ready + result).
// Depends on rmat_pkg for field widths.
`timescale 1ns / 1ps

interface rmat_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic signed [rmat_pkg::VALUE_BITS-1:0] max_value;
    logic        [rmat_pkg::SLOT_BITS-1:0]  max_slot;

    modport source (output valid, found, max_value, max_slot, input ready);
    modport sink   (input valid, found, max_value, max_slot, output ready);
endinterface

[hw/rtl/rmat_node_ram.sv]
// rmat_node_ram: generic RAM, one write port and two registered read ports.
// No package dependencies.
`timescale 1ns / 1ps

module rmat_node_ram #(
    parameter int DATA_BITS = 43,
    parameter int ADDR_BITS = 11
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re_a,
    input  logic [ADDR_BITS-1:0] raddr_a,
    output logic [DATA_BITS-1:0] rdata_a,
    input  logic                 re_b,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [DATA_BITS-1:0] rdata_b
);

    logic [DATA_BITS-1:0] mem_reg [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_a_reg;
    logic [DATA_BITS-1:0] rdata_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read ports: hold data until the next enabled read
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hw/rtl/rmat_pick.sv]
// rmat_pick: shared compare unit; picks the larger of two tree nodes.
// Depends on rmat_pkg for node_t.
`timescale 1ns / 1ps

module rmat_pick (
    input  rmat_pkg::node_t lo,
    input  rmat_pkg::node_t hi,
    output rmat_pkg::node_t win
);

    // Empty nodes never win; on equal values the lower-slot side wins
    always_comb
    begin
        priority if (!hi.full)
        begin
            win = lo;
        end
        else if (!lo.full)
        begin
            win = hi;
        end
        else if (lo.val >= hi.val)
        begin
            win = lo;
        end
        else
        begin
            win = hi;
        end
    end

endmodule

[hw/rtl/range_max_argmax_tree.sv]
// range_max_argmax_tree: segment tree giving the maximum and its lowest slot
// over a slot range. Depends on rmat_pkg, rmat_in_if, rmat_out_if,
// rmat_node_ram, rmat_pick and assert_macros.svh.
//
// Usage: items arrive on req (valid/ready). A write (opcode 0) stores value
// in slot position and gives no result; a query (opcode 1) returns found,
// max_value and max_slot for slots [position, range_end) on rsp.
// One item is worked at a time; req.ready is high only when idle.
// A write keeps the block busy after its accept: one leaf write that also
// fetches the sibling, then one step per level, merging with the sibling and
// writing the parent through the shared compare unit. The next item is taken
// only after the parent write at the root.
// A query takes, per tree level, one address step plus one compare-unit step
// for each boundary node taken, and then a final merge of the two sides.
// After reset all 2*TREE_W node addresses (2048) are swept to empty;
// req.ready stays low during the sweep.
// A finished result sits in an output register; the next item is accepted
// meanwhile, and a later query waits at its end while rsp is stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_max_argmax_tree (
    input  logic              clk,
    input  logic              rst_n,
    rmat_in_if.sink           req,
    rmat_out_if.source        rsp
);

    localparam int AB = rmat_pkg::ADDR_BITS;
    localparam int IB = rmat_pkg::IDX_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WLEAF,
        ST_WUP,
        ST_QTEST,
        ST_QACCL,
        ST_QACCR,
        ST_QDONE
    } state_t;

    state_t state_reg, state_next;
    logic [AB-1:0] clr_reg, clr_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [IB-1:0]                          lo_reg, lo_next;
    logic [IB-1:0]                          hi_reg, hi_next;
    logic [AB-1:0]                          cur_reg, cur_next;
    logic                                   tr_reg, tr_next;
    logic [rmat_pkg::POS_BITS-1:0]          pos_reg, pos_next;
    logic signed [rmat_pkg::VALUE_BITS-1:0] val_reg, val_next;
    rmat_pkg::node_t carry_reg, carry_next;
    rmat_pkg::node_t accl_reg, accl_next;
    rmat_pkg::node_t accr_reg, accr_next;
    rmat_pkg::node_t out_reg, out_next;

    // RAM and compare unit hookup
    logic                           ram_we;
    logic [AB-1:0]                  ram_waddr;
    rmat_pkg::node_t                ram_wdata;
    logic                           ram_re_a, ram_re_b;
    logic [AB-1:0]                  ram_ra, ram_rb;
    logic [rmat_pkg::NODE_BITS-1:0] ram_rd_a, ram_rd_b;
    rmat_pkg::node_t                rd_a, rd_b;
    rmat_pkg::node_t                pick_lo, pick_hi, pick_win;

    logic          accept;
    logic [IB-1:0] end_clamp;
    logic [AB-1:0] leaf;
    logic [AB-1:0] parent;

    assign rd_a = rmat_pkg::node_t'(ram_rd_a);
    assign rd_b = rmat_pkg::node_t'(ram_rd_b);

    rmat_node_ram #(
        .DATA_BITS (rmat_pkg::NODE_BITS),
        .ADDR_BITS (AB)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_ra),
        .rdata_a (ram_rd_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_rb),
        .rdata_b (ram_rd_b)
    );

    rmat_pick u_pick (
        .lo  (pick_lo),
        .hi  (pick_hi),
        .win (pick_win)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Clamp the query end to the slot count, then map slots onto leaf indexes
    assign end_clamp = (IB'(req.range_end) > IB'(rmat_pkg::LEAVES))
                       ? IB'(rmat_pkg::LEAVES) : IB'(req.range_end);
    assign leaf      = AB'(IB'(rmat_pkg::TREE_W) + IB'(pos_reg));
    assign parent    = cur_reg >> 1;

    // Select the compare unit operands for the current step
    always_comb
    begin
        unique case (state_reg)
            ST_WUP:
            begin
                pick_lo = cur_reg[0] ? rd_a : carry_reg;
                pick_hi = cur_reg[0] ? carry_reg : rd_a;
            end
            ST_QACCL:
            begin
                pick_lo = accl_reg;
                pick_hi = rd_a;
            end
            ST_QACCR:
            begin
                pick_lo = rd_b;
                pick_hi = accr_reg;
            end
            default:
            begin
                pick_lo = accl_reg;
                pick_hi = accr_reg;
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cur_next       = cur_reg;
        tr_next        = tr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        carry_next     = carry_reg;
        accl_next      = accl_reg;
        accr_next      = accr_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re_a       = 1'b0;
        ram_re_b       = 1'b0;
        ram_ra         = '0;
        ram_rb         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every node to empty
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AB'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = req.position;
                    val_next  = req.value;
                    accl_next = '0;
                    accr_next = '0;
                    lo_next   = IB'(req.position) + IB'(rmat_pkg::TREE_W);
                    hi_next   = end_clamp + IB'(rmat_pkg::TREE_W);
                    priority if (req.opcode == rmat_pkg::OP_QUERY)
                    begin
                        state_next = ST_QTEST;
                    end
                    else if (IB'(req.position) < IB'(rmat_pkg::LEAVES))
                    begin
                        state_next = ST_WLEAF;
                    end
                    else
                    begin
                        // Drop writes beyond the slots
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WLEAF:
            begin
                // Store the leaf and fetch its sibling
                ram_we          = 1'b1;
                ram_waddr       = leaf;
                ram_wdata.full  = 1'b1;
                ram_wdata.val   = val_reg;
                ram_wdata.slot  = rmat_pkg::SLOT_BITS'(pos_reg);
                carry_next      = ram_wdata;
                cur_next        = leaf;
                ram_re_a        = 1'b1;
                ram_ra          = leaf ^ AB'(1);
                state_next      = ST_WUP;
            end
            ST_WUP:
            begin
                // Merge carried node with sibling, write parent, fetch next sibling
                ram_we     = 1'b1;
                ram_waddr  = parent;
                ram_wdata  = pick_win;
                carry_next = pick_win;
                cur_next   = parent;
                if (parent == AB'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re_a = 1'b1;
                    ram_ra   = parent ^ AB'(1);
                end
            end
            ST_QTEST:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = ST_QDONE;
                end
                else
                begin
                    // Fetch boundary nodes and step both bounds up one level
                    ram_re_a = lo_reg[0];
                    ram_ra   = AB'(lo_reg);
                    ram_re_b = hi_reg[0];
                    ram_rb   = AB'(hi_reg - IB'(1));
                    tr_next  = hi_reg[0];
                    lo_next  = (lo_reg + IB'(lo_reg[0])) >> 1;
                    hi_next  = (hi_reg - IB'(hi_reg[0])) >> 1;
                    priority if (lo_reg[0])
                    begin
                        state_next = ST_QACCL;
                    end
                    else if (hi_reg[0])
                    begin
                        state_next = ST_QACCR;
                    end
                    else
                    begin
                        state_next = ST_QTEST;
                    end
                end
            end
            ST_QACCL:
            begin
                accl_next  = pick_win;
                state_next = tr_reg ? ST_QACCR : ST_QTEST;
            end
            ST_QACCR:
            begin
                accr_next  = pick_win;
                state_next = ST_QTEST;
            end
            ST_QDONE:
            begin
                // Merge the two sides; hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_next       = pick_win.full ? pick_win : '0;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        cur_reg   <= cur_next;
        tr_reg    <= tr_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        carry_reg <= carry_next;
        accl_reg  <= accl_next;
        accr_reg  <= accr_next;
        out_reg   <= out_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = out_reg.full;
    assign rsp.max_value = out_reg.val;
    assign rsp.max_slot  = out_reg.slot;

    // Checks
    `ASSERT_IMPL(a_empty_result_zero, clk, rst_n, rsp.valid && !rsp.found,
        rsp.max_value == '0 && rsp.max_slot == '0, "empty result carries nonzero payload")
    `ASSERT_NEXT(a_query_busy, clk, rst_n, accept && req.opcode == rmat_pkg::OP_QUERY,
        !req.ready, "ready after a query was accepted")
    `ASSERT_IMPL(a_ascent_below_root, clk, rst_n, state_reg == ST_WUP,
        cur_reg >= AB'(2), "write ascent reached past the root")

endmodule
